/* hw/rtl/raw_frame_rescale_palette_macros.svh */
// Assertion macros used by the checker of the palette resampler.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RAW_FRAME_RESCALE_PALETTE_MACROS_SVH
`define RAW_FRAME_RESCALE_PALETTE_MACROS_SVH

// Check cons in the same cycle as ante.
`define RFRP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RFRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rfrp_pkg.sv */
// Shared types and constants of the palette resampler.
// No dependencies; the front, queue, back and top-level modules import it.
package rfrp_pkg;

	localparam int unsigned TEXTURE_SIZE       = 256;
	localparam int unsigned TEX_W              = 8;
	localparam int unsigned DEFAULT_MAX_WIDTH  = 1024;
	localparam int unsigned DEFAULT_MAX_HEIGHT = 1024;
	localparam int unsigned MIN_WIDTH          = 4;
	localparam int unsigned MIN_HEIGHT         = 1;
	localparam int unsigned FRAC_SHIFT         = 16;
	localparam int unsigned ROW_SHIFT          = 8;
	localparam int unsigned QUEUE_DEPTH        = 4;

	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd240;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 1'b0,
		REG_SOURCE_HEIGHT = 1'b1
	} rfrp_reg_t;

	typedef enum logic {
		OP_PIXEL   = 1'b0,
		OP_PALETTE = 1'b1
	} rfrp_op_t;

	// Command word passed from front to back (the source column follows it).
	typedef struct packed {
		rfrp_op_t          kind;
		logic [7:0]        tag;     // pixel index or palette slot
		logic [31:0]       colour;  // palette color for a palette write
		logic [TEX_W-1:0]  row;     // output row of a pixel
	} rfrp_cmd_t;

endpackage

/* hw/rtl/rfrp_front.sv */
// Front end of the palette resampler: config registers, raster walk, row selection.
// Uses rfrp_pkg; feeds rfrp_queue.
module rfrp_front import rfrp_pkg::*; #(
	parameter int unsigned MAX_SOURCE_WIDTH  = DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_SOURCE_HEIGHT = DEFAULT_MAX_HEIGHT,
	localparam int unsigned CW     = $clog2(MAX_SOURCE_WIDTH),
	localparam int unsigned WW     = $clog2(MAX_SOURCE_WIDTH + 1),
	localparam int unsigned DATA_W = $bits(rfrp_cmd_t) + CW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [7:0]             pixel_index,
	input  logic [7:0]             palette_slot,
	input  logic [31:0]            palette_colour,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   push,
	output logic [DATA_W-1:0]      push_data,
	input  logic                   q_full,
	output logic [WW-1:0]          eff_width
);

	localparam int unsigned RW       = $clog2(MAX_SOURCE_HEIGHT);
	localparam int unsigned HW       = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int unsigned STEP_MAX = (MAX_SOURCE_HEIGHT > TEXTURE_SIZE) ?
		MAX_SOURCE_HEIGHT : TEXTURE_SIZE;
	localparam int unsigned AW       = $clog2(TEXTURE_SIZE * STEP_MAX + 1);

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [CW-1:0]         sc_q;
	logic [RW-1:0]         sr_q;
	logic [TEX_W:0]        nor_q;
	logic [AW-1:0]         racc_q;

	logic [HW-1:0] eff_height;
	logic [AW-1:0] row_step;
	logic          accept;
	logic          is_pixel;
	logic          row_sel;
	logic          col_end;
	logic          row_end;
	rfrp_cmd_t     cmd;

	always_comb begin
		priority if (32'(width_q) < MIN_WIDTH) begin
			eff_width = WW'(MIN_WIDTH);
		end else if (32'(width_q) > MAX_SOURCE_WIDTH) begin
			eff_width = WW'(MAX_SOURCE_WIDTH);
		end else begin
			eff_width = WW'(width_q);
		end
		priority if (32'(height_q) < MIN_HEIGHT) begin
			eff_height = HW'(MIN_HEIGHT);
		end else if (32'(height_q) > MAX_SOURCE_HEIGHT) begin
			eff_height = HW'(MAX_SOURCE_HEIGHT);
		end else begin
			eff_height = HW'(height_q);
		end
		if (32'(eff_height) > TEXTURE_SIZE) begin
			row_step = AW'(eff_height);
		end else begin
			row_step = AW'(TEXTURE_SIZE);
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_pixel = (operation == OP_PIXEL);

	// A source row is taken when the scaled output row lands on it.
	assign row_sel = !nor_q[TEX_W] && (32'(racc_q[AW-1:ROW_SHIFT]) == 32'(sr_q));
	assign col_end = (32'(sc_q) + 32'd1) >= 32'(eff_width);
	assign row_end = (32'(sr_q) + 32'd1) >= 32'(eff_height);

	// Palette writes always go back; pixels only from selected rows.
	assign push = accept && (!is_pixel || row_sel);

	always_comb begin
		cmd.kind   = rfrp_op_t'(operation);
		cmd.tag    = is_pixel ? pixel_index : palette_slot;
		cmd.colour = palette_colour;
		cmd.row    = nor_q[TEX_W-1:0];
	end

	assign push_data = {cmd, sc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			sc_q     <= '0;
			sr_q     <= '0;
			nor_q    <= '0;
			racc_q   <= '0;
		end else if (cfg_we) begin
			unique case (rfrp_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: height_q <= cfg_data;
				default:           width_q  <= width_q;
			endcase
			sc_q   <= '0;
			sr_q   <= '0;
			nor_q  <= '0;
			racc_q <= '0;
		end else if (accept && is_pixel) begin
			if (col_end) begin
				sc_q <= '0;
				if (row_end) begin
					sr_q   <= '0;
					nor_q  <= '0;
					racc_q <= '0;
				end else begin
					sr_q <= sr_q + RW'(1);
					if (row_sel) begin
						nor_q  <= nor_q + (TEX_W+1)'(1);
						racc_q <= racc_q + row_step;
					end
				end
			end else begin
				sc_q <= sc_q + CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/rfrp_queue.sv */
// Short command queue between the front and back ends.
// Uses rfrp_pkg for its default depth.
module rfrp_queue import rfrp_pkg::*; #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              full,
	output logic              empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [NW-1:0]     count_q;

	assign full     = (32'(count_q) == DEPTH);
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

/* hw/rtl/rfrp_back.sv */
// Back end of the palette resampler: palette memory, column stepping, texel output.
// Uses rfrp_pkg; drains rfrp_queue.
module rfrp_back import rfrp_pkg::*; #(
	parameter int unsigned MAX_SOURCE_WIDTH = DEFAULT_MAX_WIDTH,
	localparam int unsigned CW     = $clog2(MAX_SOURCE_WIDTH),
	localparam int unsigned WW     = $clog2(MAX_SOURCE_WIDTH + 1),
	localparam int unsigned DATA_W = $bits(rfrp_cmd_t) + CW
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              pop,
	input  logic [DATA_W-1:0] pop_data,
	input  logic              q_empty,
	input  logic [WW-1:0]     eff_width,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       texel_colour,
	output logic [7:0]        texel_column,
	output logic [7:0]        texel_row,
	output logic              run_last
);

	localparam int unsigned FW = $clog2(MAX_SOURCE_WIDTH * (TEXTURE_SIZE / 2 +
		TEXTURE_SIZE * TEXTURE_SIZE) + 1);

	typedef enum logic {
		B_IDLE,
		B_RUN
	} state_t;

	logic [31:0] palette_mem [TEXTURE_SIZE];
	logic [31:0] rdata_q;

	state_t            state_q;
	logic              out_valid_q;
	logic [31:0]       colour_q;
	logic [TEX_W-1:0]  column_q;
	logic [TEX_W-1:0]  row_q;
	logic              last_q;
	logic [FW-1:0]     cf_q;
	logic [TEX_W:0]    noc_q;
	logic [CW-1:0]     col_q;
	logic [TEX_W-1:0]  pix_row_q;

	rfrp_cmd_t     cmd;
	logic [CW-1:0] cmd_col;
	logic [FW-1:0] col_step;
	logic [FW-1:0] cf_start;
	logic [FW-1:0] cf_next;
	logic [TEX_W:0] noc_next;
	logic          out_free;
	logic          match;
	logic          match_next;
	logic          emit;

	assign {cmd, cmd_col} = pop_data;

	assign col_step = FW'(eff_width) << 8;
	assign cf_start = FW'(eff_width) << 7;
	assign cf_next  = cf_q + col_step;
	assign noc_next = noc_q + (TEX_W+1)'(1);

	assign match      = !noc_q[TEX_W] && (32'(cf_q >> FRAC_SHIFT) == 32'(col_q));
	assign match_next = !noc_next[TEX_W] && (32'(cf_next >> FRAC_SHIFT) == 32'(col_q));

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign emit     = (state_q == B_RUN) && match && out_free;

	// Single port: a palette write or a color read per popped command.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd.kind == OP_PALETTE) begin
				palette_mem[cmd.tag] <= cmd.colour;
			end else begin
				rdata_q <= palette_mem[cmd.tag];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			colour_q    <= '0;
			column_q    <= '0;
			row_q       <= '0;
			last_q      <= 1'b0;
			cf_q        <= '0;
			noc_q       <= '0;
			col_q       <= '0;
			pix_row_q   <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop && cmd.kind == OP_PIXEL) begin
						col_q     <= cmd_col;
						pix_row_q <= cmd.row;
						// Reload the column position at each row start.
						if (cmd_col == '0) begin
							cf_q  <= cf_start;
							noc_q <= '0;
						end
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (!match) begin
						state_q <= B_IDLE;
					end else if (out_free) begin
						colour_q    <= rdata_q;
						column_q    <= noc_q[TEX_W-1:0];
						row_q       <= pix_row_q;
						last_q      <= !match_next;
						cf_q        <= cf_next;
						noc_q       <= noc_next;
						if (!match_next) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign texel_colour = colour_q;
	assign texel_column = column_q;
	assign texel_row    = row_q;
	assign run_last     = last_q;

endmodule

/* hw/rtl/raw_frame_rescale_palette.sv */
// Top level of the palette-indexed frame resampler to a 256 x 256 texture.
// Uses rfrp_pkg, rfrp_front, rfrp_queue and rfrp_back.
//
// Usage:
//   Input words arrive on in_valid/in_stall in raster order. A word with
//   operation = palette write stores palette_colour at palette_slot; a pixel
//   word carries pixel_index. Each pixel on a selected row and column yields
//   one or more texel words on out_valid/out_stall, the last flagged by
//   run_last. Write source_width (index 0) and source_height (index 1) through
//   cfg_we/cfg_index/cfg_data only while idle; each write restarts the frame.
// Flow:
//   The first texel of a pixel passes the queue slot, the palette read
//   register and the texel output register. A palette write holds the back
//   end only for its pop; a selected-row pixel holds it for its pop and its
//   texels (one texel per cycle while out_stall is low); an unselected-row
//   pixel stays in the front end. Each pop uses the single palette memory
//   port. A 4-entry queue lets the front keep accepting while the back is
//   busy.
// Reset clears the raster position, the registers to 320 x 240 and all
// valids; the palette keeps no reset value. When out_stall is high on a valid
// texel, it holds and the back end waits; in_stall rises once the queue fills.
module raw_frame_rescale_palette import rfrp_pkg::*; #(
	parameter int unsigned MAX_SOURCE_WIDTH  = DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_SOURCE_HEIGHT = DEFAULT_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [7:0]             pixel_index,
	input  logic [7:0]             palette_slot,
	input  logic [31:0]            palette_colour,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            texel_colour,
	output logic [7:0]             texel_column,
	output logic [7:0]             texel_row,
	output logic                   run_last,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned CW     = $clog2(MAX_SOURCE_WIDTH);
	localparam int unsigned WW     = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int unsigned DATA_W = $bits(rfrp_cmd_t) + CW;

	// Command path: front pushes, back pops.
	logic              push;
	logic [DATA_W-1:0] push_data;
	logic              pop;
	logic [DATA_W-1:0] pop_data;
	logic              q_full;
	logic              q_empty;
	logic [WW-1:0]     eff_width;

	rfrp_front #(
		.MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
		.MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pixel_index    (pixel_index),
		.palette_slot   (palette_slot),
		.palette_colour (palette_colour),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full),
		.eff_width      (eff_width)
	);

	// Hold up to QUEUE_DEPTH commands so either side can stall alone.
	rfrp_queue #(
		.DATA_W (DATA_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	rfrp_back #(
		.MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_data     (pop_data),
		.q_empty      (q_empty),
		.eff_width    (eff_width),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.texel_colour (texel_colour),
		.texel_column (texel_column),
		.texel_row    (texel_row),
		.run_last     (run_last)
	);

endmodule

/* hw/rtl/rfrp_checker.sv */
// Port-level checks of the palette resampler, bound to its top level.
// Uses raw_frame_rescale_palette_macros.svh.
`include "raw_frame_rescale_palette_macros.svh"

module rfrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] texel_colour,
	input logic [7:0]  texel_column,
	input logic [7:0]  texel_row,
	input logic        run_last
);

	// A stalled texel stays put.
	`RFRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(texel_colour) && $stable(texel_column) && $stable(texel_row) && $stable(run_last), "stalled texel changed")

	// Inside a run the next texel follows at once, one column on, same row and color.
	`RFRP_ASSERT_NEXT(a_run_step, out_valid && !out_stall && !run_last, out_valid && (texel_column == 8'($past(texel_column) + 8'd1)) && (texel_row == $past(texel_row)) && (texel_colour == $past(texel_colour)), "texel run broke")

	// The last texture column always closes its run.
	`RFRP_ASSERT_SAME(a_edge_last, out_valid && (texel_column == 8'hFF), run_last, "run passed last column")

endmodule

bind raw_frame_rescale_palette rfrp_checker u_rfrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.texel_colour (texel_colour),
	.texel_column (texel_column),
	.texel_row    (texel_row),
	.run_last     (run_last)
);
